FILE: design/scs_pkg.sv
// shared types, constants and a helper function for the sine/cosine series block
package scs_pkg;

    localparam logic signed [31:0] PI_Q24     = 32'sd52707179;
    localparam logic signed [31:0] NEG_PI_Q24 = -32'sd52707179;
    localparam logic signed [31:0] TWO_PI_Q24 = 32'sd105414358;
    localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;

    // iteration counter width covers up to 20 terms
    localparam int ITER_W = 5;
    // divisor (2i)(2i+1) stays below 2048 for 20 terms
    localparam int DIV_W = 11;
    // quotient bits produced per divider cycle
    localparam int DIG_BITS = 8;
    // four partial products plus one drain step
    localparam int MUL_LAST = 4;

    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_INIT,
        ST_SQUARE,
        ST_SQ_DONE,
        ST_ACCUM,
        ST_MULT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              load;
        logic              reduce;
        logic              init;
        logic              square;
        logic              mul_issue;
        logic [1:0]        mul_idx;
        logic              mul_clear;
        logic              mul_accum;
        logic              x2_load;
        logic              accum;
        logic              from_quot;
        logic              div_load;
        logic              div_step;
        logic              out_load;
        logic              is_cos;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic reduced;
    } status_t;

    // series divisor: (2i)(2i+1) for sine, (2i-1)(2i) for cosine
    function automatic logic [DIV_W-1:0] divisor_of(input logic [ITER_W-1:0] i,
                                                    input logic is_cos);
        logic [ITER_W:0]     n2;
        logic [ITER_W:0]     lo;
        logic [ITER_W:0]     hi;
        logic [2*ITER_W+1:0] prod;
        n2   = {i, 1'b0};
        lo   = is_cos ? n2 - (ITER_W+1)'(1) : n2;
        hi   = is_cos ? n2 : n2 + (ITER_W+1)'(1);
        prod = (2*ITER_W+2)'(lo) * (2*ITER_W+2)'(hi);
        return prod[DIV_W-1:0];
    endfunction

endpackage

FILE: design/sine_cosine_series.sv
// top level: sine/cosine by fixed-point Taylor series with stream ports
// One beat in gives one beat out. s_tuser selects sine (0) or cosine (1); s_tdata carries the
// angle in signed Q8.24 radians, and m_tdata returns the result in signed Q2.30, saturated to
// plus or minus one. The angle is first brought into [-pi, pi] by one add or subtract of 2*pi
// per cycle (r steps, r up to 20 over the full input range), then x squared is formed and
// each series term takes one multiply on a shared 24x24 multiplier, one divide by the
// term's constant on a divider that yields 8 quotient bits a cycle, and one add. A new beat
// is taken only once the previous result is in the output register, where it waits so the
// next beat can start meanwhile.
module sine_cosine_series #(
    parameter int TERMS              = 14,
    parameter int INTERNAL_FRAC_BITS = 44
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);
    import scs_pkg::*;

    cmd_t    cmd;
    status_t status;

    scs_ctrl #(
        .TERMS              (TERMS),
        .INTERNAL_FRAC_BITS (INTERNAL_FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .operation (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    scs_dp #(
        .INTERNAL_FRAC_BITS (INTERNAL_FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .angle  (s_tdata),
        .cmd    (cmd),
        .status (status),
        .value  (m_tdata)
    );

endmodule

FILE: design/scs_dp.sv
// datapath: range reduction, shared multiplier, radix-256 divider, series sum
module scs_dp #(
    parameter int INTERNAL_FRAC_BITS = 44
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     angle,
    input  scs_pkg::cmd_t   cmd,
    output scs_pkg::status_t status,
    output logic [31:0]     value
);
    import scs_pkg::*;

    localparam int FB        = INTERNAL_FRAC_BITS;
    localparam int MAG_W     = FB + 4;
    localparam int HALF      = (MAG_W + 1) / 2;
    localparam int PROD_W    = 2 * HALF;
    localparam int ACC_W     = 2 * MAG_W;
    localparam int PM_W      = FB + 8;
    localparam int DIV_STEPS = (PM_W + DIG_BITS - 1) / DIG_BITS;
    localparam int DVD_W     = DIV_STEPS * DIG_BITS;
    localparam int SUM_W     = FB + 5;
    localparam int OUT_SH    = FB - 30;
    localparam int V_W       = SUM_W - OUT_SH;

    localparam logic signed [V_W-1:0] V_POS = V_W'(ONE_Q30);
    localparam logic signed [V_W-1:0] V_NEG = -V_POS;

    logic signed [31:0]      x_reg, x_next;
    logic [MAG_W-1:0]        xr_reg, xr_next;
    logic [MAG_W-1:0]        x2_reg, x2_next;
    logic [MAG_W-1:0]        term_mag_reg, term_mag_next;
    logic                    term_neg_reg, term_neg_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [1:0]              prod_idx_reg, prod_idx_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]        divisor_reg, divisor_next;
    logic [31:0]             value_reg, value_next;

    logic                    gt_pi, lt_neg_pi;
    logic [31:0]             abs_x;
    logic [MAG_W-1:0]        xr_calc;
    logic [MAG_W-1:0]        op_a, op_b;
    logic [HALF-1:0]         a_lo, a_hi, b_lo, b_hi, ca, cb;
    logic [ACC_W-1:0]        shifted;
    logic [PM_W-1:0]         pm_adj;
    logic                    frac_nz;
    logic [DIV_W:0]          trial;
    logic [DIV_W-1:0]        r_work;
    logic [DIG_BITS-1:0]     q_bits;
    logic                    src_neg;
    logic [MAG_W-1:0]        src_mag;
    logic signed [SUM_W-1:0] src_ext;
    logic signed [V_W-1:0]   v_shift;

    assign gt_pi          = x_reg > PI_Q24;
    assign lt_neg_pi      = x_reg < NEG_PI_Q24;
    assign status.reduced = !gt_pi && !lt_neg_pi;

    assign abs_x   = x_reg[31] ? 32'(-x_reg) : 32'(x_reg);
    assign xr_calc = MAG_W'(abs_x[25:0]) << (FB - 24);

    // operand select and partial-product chunking
    assign op_a = cmd.square ? xr_reg : term_mag_reg;
    assign op_b = cmd.square ? xr_reg : x2_reg;
    assign a_lo = op_a[HALF-1:0];
    assign a_hi = HALF'(op_a[MAG_W-1:HALF]);
    assign b_lo = op_b[HALF-1:0];
    assign b_hi = HALF'(op_b[MAG_W-1:HALF]);

    always_comb
    begin
        case (cmd.mul_idx)
            2'd0:    begin ca = a_lo; cb = b_lo; end
            2'd1:    begin ca = a_lo; cb = b_hi; end
            2'd2:    begin ca = a_hi; cb = b_lo; end
            default: begin ca = a_hi; cb = b_hi; end
        endcase
    end

    always_comb
    begin
        case (prod_idx_reg) inside
            2'd0:    shifted = ACC_W'(prod_reg);
            2'd1,
            2'd2:    shifted = ACC_W'(prod_reg) << HALF;
            default: shifted = ACC_W'(prod_reg) << (2 * HALF);
        endcase
    end

    // floor of a negative product needs the magnitude rounded up
    assign frac_nz = |acc_reg[FB-1:0];
    assign pm_adj  = acc_reg[ACC_W-1:FB] + PM_W'(term_neg_reg & frac_nz);

    // eight restoring division steps per cycle on the narrow remainder
    always_comb
    begin
        r_work = rem_reg;
        q_bits = '0;
        trial  = '0;
        for (int k = 0; k < DIG_BITS; k++)
        begin
            trial = {r_work, dvd_reg[DVD_W-1-k]};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial                  = trial - {1'b0, divisor_reg};
                q_bits[DIG_BITS-1-k]   = 1'b1;
            end
            r_work = trial[DIV_W-1:0];
        end
    end

    // a new term from the divider takes the sign opposite to the product
    assign src_neg = cmd.from_quot ? !term_neg_reg : term_neg_reg;
    assign src_mag = cmd.from_quot ? dvd_reg[MAG_W-1:0] : term_mag_reg;
    assign src_ext = $signed({1'b0, src_mag});

    assign v_shift = sum_reg[SUM_W-1:OUT_SH];

    always_comb
    begin
        x_next        = x_reg;
        xr_next       = xr_reg;
        x2_next       = x2_reg;
        term_mag_next = term_mag_reg;
        term_neg_next = term_neg_reg;
        sum_next      = sum_reg;
        prod_next     = prod_reg;
        prod_idx_next = prod_idx_reg;
        acc_next      = acc_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        value_next    = value_reg;

        if (cmd.load)
            x_next = $signed(angle);
        if (cmd.reduce)
        begin
            if (gt_pi)
                x_next = x_reg - TWO_PI_Q24;
            else if (lt_neg_pi)
                x_next = x_reg + TWO_PI_Q24;
        end
        if (cmd.init)
        begin
            xr_next = xr_calc;
            if (cmd.is_cos == OP_COSINE)
            begin
                term_mag_next = MAG_W'(1) << FB;
                term_neg_next = 1'b0;
                sum_next      = SUM_W'(1) << FB;
            end
            else
            begin
                term_mag_next = xr_calc;
                term_neg_next = x_reg[31];
                sum_next      = '0;
            end
        end
        if (cmd.mul_issue)
        begin
            prod_next     = PROD_W'(ca) * PROD_W'(cb);
            prod_idx_next = cmd.mul_idx;
        end
        if (cmd.mul_clear)
            acc_next = '0;
        else if (cmd.mul_accum)
            acc_next = acc_reg + shifted;
        if (cmd.x2_load)
            x2_next = acc_reg[FB +: MAG_W];
        if (cmd.div_load)
        begin
            dvd_next     = DVD_W'(pm_adj);
            rem_next     = '0;
            divisor_next = divisor_of(cmd.iter, cmd.is_cos);
        end
        else if (cmd.div_step)
        begin
            dvd_next = {dvd_reg[DVD_W-DIG_BITS-1:0], q_bits};
            rem_next = r_work;
        end
        if (cmd.accum)
        begin
            term_mag_next = src_mag;
            term_neg_next = src_neg;
            sum_next      = src_neg ? sum_reg - src_ext : sum_reg + src_ext;
        end
        if (cmd.out_load)
        begin
            if (v_shift > V_POS)
                value_next = 32'(V_POS);
            else if (v_shift < V_NEG)
                value_next = 32'(V_NEG);
            else
                value_next = v_shift[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        xr_reg       <= xr_next;
        x2_reg       <= x2_next;
        term_mag_reg <= term_mag_next;
        term_neg_reg <= term_neg_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        prod_idx_reg <= prod_idx_next;
        acc_reg      <= acc_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        value_reg    <= value_next;
    end

    assign value = value_reg;

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> ($signed(value_reg) <= ONE_Q30 && $signed(value_reg) >= -ONE_Q30))
        else $error("result outside plus or minus one");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    a_reduced_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.reduce && status.reduced) |=> $stable(x_reg))
        else $error("reduced angle moved");

endmodule

FILE: design/scs_ctrl.sv
// controller: sequences reduction, squaring and the per-term multiply, divide, add
module scs_ctrl #(
    parameter int TERMS              = 14,
    parameter int INTERNAL_FRAC_BITS = 44
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             operation,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  scs_pkg::status_t status,
    output scs_pkg::cmd_t    cmd
);
    import scs_pkg::*;

    localparam int PM_W      = INTERNAL_FRAC_BITS + 8;
    localparam int DIV_STEPS = (PM_W + DIG_BITS - 1) / DIG_BITS;
    localparam int STEP_MAX  = (DIV_STEPS > MUL_LAST) ? DIV_STEPS : MUL_LAST;
    localparam int STEP_W    = $clog2(STEP_MAX + 1);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                op_reg, op_next;
    logic                out_valid_reg, out_valid_next;
    logic                last_term;

    assign last_term = (iter_reg == ITER_W'(TERMS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            iter_reg      <= '0;
            op_reg        <= OP_SINE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            iter_reg      <= iter_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        iter_next  = iter_reg;
        op_next    = op_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.iter   = iter_reg;
        cmd.is_cos = op_reg;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = operation;
                    iter_next  = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (status.reduced)
                    state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                step_next  = '0;
                state_next = ST_SQUARE;
            end
            ST_SQUARE,
            ST_MULT:
            begin
                cmd.square = (state_reg == ST_SQUARE);
                cmd.mul_idx = step_reg[1:0];
                if (step_reg != STEP_W'(MUL_LAST))
                    cmd.mul_issue = 1'b1;
                if (step_reg == '0)
                    cmd.mul_clear = 1'b1;
                else
                    cmd.mul_accum = 1'b1;
                if (step_reg == STEP_W'(MUL_LAST))
                begin
                    step_next  = '0;
                    state_next = (state_reg == ST_SQUARE) ? ST_SQ_DONE : ST_DIVIDE;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_SQ_DONE:
            begin
                cmd.x2_load = 1'b1;
                iter_next   = ITER_W'(1);
                state_next  = (op_reg == OP_COSINE) ? ST_MULT : ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum     = 1'b1;
                // first sine term is the angle itself, later ones come from the divider
                cmd.from_quot = (op_reg == OP_COSINE) || (iter_reg != ITER_W'(1));
                step_next     = '0;
                if (op_reg == OP_COSINE && last_term)
                    state_next = ST_FINISH;
                else
                begin
                    if (op_reg == OP_COSINE)
                        iter_next = iter_reg + ITER_W'(1);
                    state_next = ST_MULT;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == '0)
                    cmd.div_load = 1'b1;
                else
                    cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS))
                begin
                    step_next = '0;
                    if (op_reg == OP_COSINE)
                        state_next = ST_ACCUM;
                    else if (last_term)
                        state_next = ST_FINISH;
                    else
                    begin
                        iter_next  = iter_reg + ITER_W'(1);
                        state_next = ST_ACCUM;
                    end
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output beat overwritten before taken");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (iter_reg <= ITER_W'(TERMS)))
        else $error("term counter past last term");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_REDUCE))
        else $error("accepted beat did not start reduction");

endmodule

FILE: dv/tb_top.sv
// testbench for sine_cosine_series: directed angle table plus random beats, checked in order
`timescale 1ns / 1ps

module tb_top;
    import scs_pkg::*;

    localparam int SERIES_TERMS = 14;
    localparam int FRAC         = 44;
    localparam int RANDOM_BEATS = 1800;
    localparam int DRAIN_CYCLES = 300;

    // one directed beat; value is only used where known is set
    typedef struct packed {
        logic        op;
        logic [31:0] angle;
        logic        known;
        logic [31:0] value;
    } probe_t;

    localparam int NPROBES = 21;
    localparam probe_t PROBES [0:NPROBES-1] = '{
        '{OP_SINE,   32'd0,                   1'b1, 32'd0},
        '{OP_COSINE, 32'd0,                   1'b1, ONE_Q30},
        '{OP_SINE,   TWO_PI_Q24,              1'b1, 32'd0},
        '{OP_COSINE, TWO_PI_Q24,              1'b1, ONE_Q30},
        '{OP_SINE,   -TWO_PI_Q24,             1'b1, 32'd0},
        '{OP_COSINE, -TWO_PI_Q24,             1'b1, ONE_Q30},
        '{OP_SINE,   PI_Q24,                  1'b0, 32'd0},
        '{OP_COSINE, PI_Q24,                  1'b0, 32'd0},
        '{OP_SINE,   NEG_PI_Q24,              1'b0, 32'd0},
        '{OP_COSINE, NEG_PI_Q24,              1'b0, 32'd0},
        '{OP_SINE,   PI_Q24 + 32'sd1,         1'b0, 32'd0},
        '{OP_COSINE, NEG_PI_Q24 - 32'sd1,     1'b0, 32'd0},
        '{OP_SINE,   32'h7FFF_FFFF,           1'b0, 32'd0},
        '{OP_COSINE, 32'h7FFF_FFFF,           1'b0, 32'd0},
        '{OP_SINE,   32'h8000_0000,           1'b0, 32'd0},
        '{OP_COSINE, 32'h8000_0000,           1'b0, 32'd0},
        '{OP_SINE,   32'd1,                   1'b0, 32'd0},
        '{OP_COSINE, 32'hFFFF_FFFF,           1'b0, 32'd0},
        '{OP_SINE,   32'sd26353590,           1'b0, 32'd0},
        '{OP_COSINE, 32'sd26353590,           1'b0, 32'd0},
        '{OP_SINE,   -32'sd26353590,          1'b0, 32'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    logic [31:0] expected_values [$];
    int          fails;
    int          checked;
    int          sine_beats;
    int          cosine_beats;
    int          wrapped_beats;
    logic        quiet;
    logic        rx_enable;
    logic [31:0] want;

    sine_cosine_series #(
        .TERMS              (SERIES_TERMS),
        .INTERNAL_FRAC_BITS (FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // floor(a*b / 2^FRAC) from the magnitudes, magnitude rounded up when the product is negative
    function automatic longint scaled_product(input longint a, input longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic         neg;
        logic         rem;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        mag  = prod[FRAC+63:FRAC];
        rem  = |prod[FRAC-1:0];
        mag[63:62] = 2'b00;
        if (neg)
            return -$signed(mag + {63'd0, rem});
        return $signed(mag);
    endfunction

    function automatic logic [31:0] series_value(input logic op, input logic [31:0] angle);
        longint ang;
        longint xr;
        longint x2;
        longint total;
        longint term;
        longint p;
        longint v;
        longint k;
        ang = longint'($signed(angle));
        while (ang > longint'(PI_Q24))
            ang -= longint'(TWO_PI_Q24);
        while (ang < -longint'(PI_Q24))
            ang += longint'(TWO_PI_Q24);
        xr = ang <<< (FRAC - 24);
        x2 = scaled_product(xr, xr);
        if (op == OP_SINE)
        begin
            total = 0;
            term  = xr;
            for (k = 1; k <= SERIES_TERMS; k++)
            begin
                total += term;
                p      = scaled_product(term, x2);
                term   = -(p / ((2 * k) * (2 * k + 1)));
            end
        end
        else
        begin
            total = longint'(1) <<< FRAC;
            term  = total;
            for (k = 1; k <= SERIES_TERMS; k++)
            begin
                p      = scaled_product(term, x2);
                term   = -(p / ((2 * k - 1) * (2 * k)));
                total += term;
            end
        end
        v = total >>> (FRAC - 30);
        if (v > longint'(ONE_Q30))
            v = longint'(ONE_Q30);
        if (v < -longint'(ONE_Q30))
            v = -longint'(ONE_Q30);
        return v[31:0];
    endfunction

    // mostly no gap (none while quiet), some short ones, a few long enough to land anywhere in a beat's work
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        return $urandom_range(5, 260);
    endfunction

    function automatic logic [31:0] random_angle();
        longint a;
        int     sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: a = longint'($urandom_range(0, 2 * PI_Q24)) - PI_Q24;
            4, 5:       a = longint'($signed($urandom));
            6:          a = ($urandom_range(0, 1) ? 1 : -1) *
                            (longint'(PI_Q24) + $urandom_range(0, 8) - 4);
            7:          a = (longint'($urandom_range(0, 40)) - 20) * TWO_PI_Q24 +
                            $urandom_range(0, 16) - 8;
            8:          a = longint'($urandom_range(0, 511)) - 256;
            default:    a = (longint'($urandom_range(0, 80)) - 40) * 26353590 +
                            $urandom_range(0, 64) - 32;
        endcase
        return a[31:0];
    endfunction

    task automatic send_beat(input logic op, input logic [31:0] angle, input logic known,
                             input logic [31:0] value);
        int gap;
        gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= angle;
        do
            @(posedge clk);
        while (!s_tready);
        expected_values.push_back(known ? value : series_value(op, angle));
        if (op == OP_SINE)
            sine_beats++;
        else
            cosine_beats++;
        if ($signed(angle) > PI_Q24 || $signed(angle) < NEG_PI_Q24)
            wrapped_beats++;
    endtask

    task automatic wait_drained();
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    // result side: random back-pressure, off during quiet stretches
    initial
    begin
        int stall;
        stall = 0;
        wait (rx_enable);
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !quiet)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_values.size() == 0)
            begin
                $error("unexpected result beat: value actual %0d", $signed(m_tdata));
                fails++;
            end
            else
            begin
                want = expected_values.pop_front();
                checked++;
                if (m_tdata !== want)
                begin
                    $error("value mismatch: expected %0d actual %0d",
                           $signed(want), $signed(m_tdata));
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int n;
        logic op;
        fails         = 0;
        checked       = 0;
        sine_beats    = 0;
        cosine_beats  = 0;
        wrapped_beats = 0;
        quiet         = 1'b0;
        rx_enable     = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 32'd0;
        s_tuser       = OP_SINE;
        m_tready      = 1'b0;
        rst_n         = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        rx_enable = 1'b1;

        for (n = 0; n < NPROBES; n++)
            send_beat(PROBES[n].op, PROBES[n].angle, PROBES[n].known, PROBES[n].value);

        // hold off the sender until the directed results are all back
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            quiet = (n >= 1000 && n < 1150);
            if (n == 900)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait_drained();
            end
            op = 1'($urandom_range(0, 1));
            send_beat(op, random_angle(), 1'b0, 32'd0);
        end
        quiet = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d sine and %0d cosine beats, %0d needing range reduction",
                 sine_beats, cosine_beats, wrapped_beats);
        $display("%0d results compared, %0d failures", checked, fails);
        if (fails == 0 && expected_values.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sine_cosine_series.f
design/scs_pkg.sv
design/scs_dp.sv
design/scs_ctrl.sv
design/sine_cosine_series.sv
dv/tb_top.sv
